@@ rtl/core/dmr_pkg.sv @@
// Shared types, codes and constants for the device match registry.
`timescale 1ns / 1ps
`default_nettype none
package dmr_pkg;

    // Rule table depth
    localparam int TABLE_DEPTH = 16;

    // Match flag bit positions
    localparam int FL_DEVNO   = 0;
    localparam int FL_CHARS   = 1;
    localparam int FL_EXACT   = 2;
    localparam int FL_NOCU    = 3;
    localparam int FL_NODEV   = 4;
    localparam int FL_CUTYPE  = 5;
    localparam int FL_DEVTYPE = 6;

    // Flag pattern for an exact-characteristics rule
    localparam logic [6:0] FLAGS_EXACT_CHARS = 7'b000_0110;

    // Characteristics field masks: cu_type, cu_model, dev_type, dev_model
    localparam logic [47:0] CH_CUTYPE  = 48'hFFFF_0000_0000;
    localparam logic [47:0] CH_CUMODEL = 48'h0000_FF00_0000;
    localparam logic [47:0] CH_DVTYPE  = 48'h0000_00FF_FF00;
    localparam logic [47:0] CH_DVMODEL = 48'h0000_0000_00FF;
    localparam logic [47:0] CH_ALL     = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_REG    = 2'd0,
        OP_UNREG  = 2'd1,
        OP_SEARCH = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Captured request, broadcast to every cell
    typedef struct packed {
        t_op         op;
        logic [7:0]  handle;
        logic [6:0]  flags;
        logic [15:0] devno;
        logic        devno_valid;
        logic [47:0] chars;
    } t_req;

    // Stored rule payload
    typedef struct packed {
        logic [6:0]  flags;
        logic [7:0]  handle;
        logic [15:0] devno;
        logic [47:0] chars;
    } t_rule;

    typedef struct packed {
        logic  valid;
        t_rule rule;
    } t_entry;

    // First-hit scan result handed from cell to cell, newest first
    typedef struct packed {
        logic       hit;
        t_status    code;
        logic [7:0] handle;
    } t_chain;

    // Table update command from the controller
    typedef struct packed {
        logic ins;
        logic del;
    } t_cmd;

endpackage
`default_nettype wire

@@ rtl/core/dmr_cell.sv @@
// One slot of the rule table: holds a rule, compares it and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module dmr_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dmr_pkg::t_req   i_req,
    input  wire dmr_pkg::t_cmd   i_cmd,
    input  wire dmr_pkg::t_entry i_prev,
    input  wire dmr_pkg::t_entry i_next,
    input  wire dmr_pkg::t_chain i_chain,
    output dmr_pkg::t_chain      o_chain,
    output dmr_pkg::t_entry      o_entry
);
    import dmr_pkg::*;

    logic        r_valid;
    t_rule       r_rule;
    t_entry      n_entry;
    logic        w_upd;
    logic        w_h_eq;
    logic        w_d_eq;
    logic        w_c_eq;
    logic        w_cm;
    logic [47:0] w_mask;
    t_chain      w_local;

    assign o_entry = '{valid: r_valid, rule: r_rule};

    // Per-rule characteristics mask
    always_comb begin
        w_mask = CH_ALL;
        if (!r_rule.flags[FL_EXACT]) begin
            if (r_rule.flags[FL_NOCU])    w_mask = w_mask & ~(CH_CUTYPE | CH_CUMODEL);
            if (r_rule.flags[FL_NODEV])   w_mask = w_mask & ~(CH_DVTYPE | CH_DVMODEL);
            if (r_rule.flags[FL_CUTYPE])  w_mask = w_mask & ~CH_CUMODEL;
            if (r_rule.flags[FL_DEVTYPE]) w_mask = w_mask & ~CH_DVMODEL;
        end
    end

    // Field compares against the request
    assign w_h_eq = (r_rule.handle == i_req.handle);
    assign w_d_eq = (r_rule.devno == i_req.devno);
    assign w_c_eq = (r_rule.chars == i_req.chars);
    assign w_cm   = (((r_rule.chars ^ i_req.chars) & w_mask) == '0);

    // Local hit for the current request
    always_comb begin
        w_local.hit    = 1'b0;
        w_local.code   = ST_OK;
        w_local.handle = r_rule.handle;
        unique case (i_req.op)
            OP_REG: begin
                w_local.hit  = r_valid & (w_h_eq
                             | (r_rule.flags[FL_DEVNO] & i_req.flags[FL_DEVNO] & w_d_eq)
                             | ((i_req.flags == FLAGS_EXACT_CHARS) & w_c_eq));
                w_local.code = w_h_eq ? ST_INVALID : ST_BUSY;
            end
            OP_UNREG: begin
                w_local.hit = r_valid & w_h_eq;
            end
            OP_SEARCH: begin
                w_local.hit = r_valid
                            & ((r_rule.flags[FL_DEVNO] & i_req.devno_valid & w_d_eq)
                            |  (r_rule.flags[FL_CHARS] & w_cm));
            end
            default: begin
                w_local.hit = 1'b0;
            end
        endcase
    end

    // Newer slot's hit wins
    assign o_chain = i_chain.hit ? i_chain : w_local;

    // Insert takes the newer neighbor; removal at or above takes the older one
    always_comb begin
        w_upd   = 1'b0;
        n_entry = i_prev;
        if (i_cmd.ins) begin
            w_upd   = 1'b1;
            n_entry = i_prev;
        end else if (i_cmd.del && (i_chain.hit || w_local.hit)) begin
            w_upd   = 1'b1;
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_upd) begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_rule <= n_entry.rule;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/device_match_registry_unit.sv @@
// Top level of the device match registry: request capture, cell chain and result register.
// The request register captures a request when it is accepted; the result register then loads
//   from the execute step once the result register is free, and o_valid rises with it.
// A new request is not accepted until the single execute step, a first-hit
//   scan rippling through the row of slot cells, has finished.
// A stall on the result side holds the execute step until the result register frees.
// Reset clears all slot valid bits, the state machine and the result valid bit.
`timescale 1ns / 1ps
`default_nettype none
module device_match_registry_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_handle,
    input  wire logic [6:0]  i_match_flags,
    input  wire logic [15:0] i_dev_number,
    input  wire logic        i_dev_number_valid,
    input  wire logic [15:0] i_cu_type,
    input  wire logic [7:0]  i_cu_model,
    input  wire logic [15:0] i_dev_type,
    input  wire logic [7:0]  i_dev_model,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [7:0]       o_found_handle
);
    import dmr_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_req       r_req;
    logic       r_out_valid;
    t_status    r_status;
    logic       r_found;
    logic [7:0] r_fhandle;

    logic       w_accept;
    logic       w_out_free;
    logic       w_done;
    t_cmd       w_cmd;
    t_status    w_status;
    logic       w_found;
    logic [7:0] w_fhandle;
    t_entry     w_new;

    t_entry w_entry [TABLE_DEPTH];
    t_entry w_prev  [TABLE_DEPTH];
    t_entry w_next  [TABLE_DEPTH];
    t_chain w_chain [TABLE_DEPTH+1];

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.op          <= t_op'(i_req_type);
            r_req.handle      <= i_handle;
            r_req.flags       <= i_match_flags;
            r_req.devno       <= i_dev_number;
            r_req.devno_valid <= i_dev_number_valid;
            r_req.chars       <= {i_cu_type, i_cu_model, i_dev_type, i_dev_model};
        end
    end

    // New rule entering at the head
    assign w_new = '{valid: 1'b1,
                     rule: '{flags: r_req.flags, handle: r_req.handle,
                             devno: r_req.devno, chars: r_req.chars}};

    // Row of slot cells, newest at index 0
    assign w_chain[0] = '{hit: 1'b0, code: ST_OK, handle: 8'd0};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev[g] = w_new;
        end else begin : g_body
            assign w_prev[g] = w_entry[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_next[g] = '0;
        end else begin : g_inner
            assign w_next[g] = w_entry[g+1];
        end

        dmr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_cmd   (w_cmd),
            .i_prev  (w_prev[g]),
            .i_next  (w_next[g]),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_entry (w_entry[g])
        );
    end

    // Result and table command from the scan
    always_comb begin
        w_status  = ST_OK;
        w_found   = 1'b0;
        w_fhandle = 8'd0;
        w_cmd     = '{ins: 1'b0, del: 1'b0};
        unique case (r_req.op)
            OP_REG: begin
                if (!r_req.flags[FL_DEVNO] && !r_req.flags[FL_CHARS]) begin
                    w_status = ST_INVALID;
                end else if (w_chain[TABLE_DEPTH].hit) begin
                    w_status = w_chain[TABLE_DEPTH].code;
                end else if (w_entry[TABLE_DEPTH-1].valid) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.ins = w_done;
                end
            end
            OP_UNREG: begin
                if (w_chain[TABLE_DEPTH].hit) begin
                    w_cmd.del = w_done;
                end else begin
                    w_status = ST_INVALID;
                end
            end
            OP_SEARCH: begin
                w_found   = w_chain[TABLE_DEPTH].hit;
                w_fhandle = w_chain[TABLE_DEPTH].hit ? w_chain[TABLE_DEPTH].handle : 8'd0;
            end
            default: begin
                w_status = ST_INVALID;
            end
        endcase
    end

    // State machine: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State machine: outputs
    always_comb begin
        o_stall = 1'b1;
        w_done  = 1'b0;
        unique case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_EXEC: w_done  = w_out_free;
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_status  <= w_status;
            r_found   <= w_found;
            r_fhandle <= w_fhandle;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_found_handle = r_fhandle;

endmodule
`default_nettype wire

@@ rtl/core/dmr_checker.sv @@
// Port-level checks for the device match registry, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dmr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_status,
    input wire logic       o_found,
    input wire logic [7:0] o_found_handle
);
    import dmr_pkg::*;

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // One request in flight: an accept blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while another executes");

    // A found result is always a successful search
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ST_OK))
        else $error("found with non-ok status");

    // No match reports a zero handle
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_found_handle == 8'd0))
        else $error("nonzero handle without a match");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_found)
                                  && $stable(o_found_handle)))
        else $error("stalled result changed");

endmodule

bind device_match_registry_unit dmr_checker u_dmr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_found        (o_found),
    .o_found_handle (o_found_handle)
);
`default_nettype wire

@@ sim/dmr_result_checker.sv @@
// Result checker for the device match registry: rule table predictor and result compare.
`timescale 1ns / 1ps
module dmr_result_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // request channel
    input  logic            i_req_valid,
    input  logic            i_req_stall,
    input  dmr_pkg::t_req   i_req,
    // result channel
    input  logic            i_rsp_valid,
    input  logic            i_rsp_stall,
    input  logic [1:0]      i_status,
    input  logic            i_found,
    input  logic [7:0]      i_found_handle,
    output int              o_fail_count,
    output int              o_pending
);
    import dmr_pkg::*;

    localparam int SHOW_MAX = 10;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [7:0] fhandle;
    } t_answer;

    // Shadow rule table, newest rule at slot 0
    t_rule   rules [TABLE_DEPTH];
    int      rule_cnt;
    t_answer answer_q [$];
    int      fail_n;
    int      shown_n;

    assign o_fail_count = fail_n;

    // Apply one request to the shadow table and work out its answer
    task automatic resolve_request(input t_req rq, output t_answer ans);
        int          i;
        int          j;
        logic        done;
        logic        hit;
        logic [47:0] mask;
        ans = '{ST_OK, 1'b0, 8'h00};
        case (rq.op)
            OP_REG: begin
                if (!rq.flags[FL_DEVNO] && !rq.flags[FL_CHARS]) begin
                    ans.status = ST_INVALID;
                end else begin
                    // first conflicting rule, newest first, decides
                    for (i = 0; i < rule_cnt && ans.status == ST_OK; i++) begin
                        if (rules[i].handle == rq.handle)
                            ans.status = ST_INVALID;
                        else if (rules[i].flags[FL_DEVNO] && rq.flags[FL_DEVNO] &&
                                 rules[i].devno == rq.devno)
                            ans.status = ST_BUSY;
                        else if (rq.flags == FLAGS_EXACT_CHARS && rules[i].chars == rq.chars)
                            ans.status = ST_BUSY;
                    end
                    if (ans.status == ST_OK && rule_cnt >= TABLE_DEPTH)
                        ans.status = ST_FULL;
                    if (ans.status == ST_OK) begin
                        for (i = rule_cnt; i > 0; i--)
                            rules[i] = rules[i - 1];
                        rules[0] = '{rq.flags, rq.handle, rq.devno, rq.chars};
                        rule_cnt++;
                    end
                end
            end
            OP_UNREG: begin
                ans.status = ST_INVALID;
                done = 1'b0;
                for (i = 0; i < rule_cnt && !done; i++) begin
                    if (rules[i].handle == rq.handle) begin
                        // close the gap
                        for (j = i; j + 1 < rule_cnt; j++)
                            rules[j] = rules[j + 1];
                        rule_cnt--;
                        ans.status = ST_OK;
                        done = 1'b1;
                    end
                end
            end
            OP_SEARCH: begin
                for (i = 0; i < rule_cnt && !ans.found; i++) begin
                    hit = 1'b0;
                    if (rules[i].flags[FL_DEVNO] && rq.devno_valid &&
                        rules[i].devno == rq.devno) begin
                        hit = 1'b1;
                    end else if (rules[i].flags[FL_CHARS]) begin
                        // exact ignores the masks
                        mask = CH_ALL;
                        if (!rules[i].flags[FL_EXACT]) begin
                            if (rules[i].flags[FL_NOCU])    mask &= ~(CH_CUTYPE | CH_CUMODEL);
                            if (rules[i].flags[FL_NODEV])   mask &= ~(CH_DVTYPE | CH_DVMODEL);
                            if (rules[i].flags[FL_CUTYPE])  mask &= ~CH_CUMODEL;
                            if (rules[i].flags[FL_DEVTYPE]) mask &= ~CH_DVMODEL;
                        end
                        hit = ((rules[i].chars ^ rq.chars) & mask) == 48'h0;
                    end
                    if (hit) begin
                        ans.found   = 1'b1;
                        ans.fhandle = rules[i].handle;
                    end
                end
            end
            default: begin
                ans.status = ST_INVALID;
            end
        endcase
    endtask

    initial rule_cnt = 0;

    // Compare results first, then queue the answer of a new request
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        t_answer pred;
        if (i_rst_n) begin
            if (i_rsp_valid && !i_rsp_stall) begin
                got = '{i_status, i_found, i_found_handle};
                if (answer_q.size() == 0) begin
                    fail_n++;
                    if (shown_n < SHOW_MAX) begin
                        shown_n++;
                        $display("%0t: result without request: status %0d found %0d handle %02h",
                                 $time, got.status, got.found, got.fhandle);
                    end
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.fhandle !== want.fhandle) begin
                        fail_n++;
                        if (shown_n < SHOW_MAX) begin
                            shown_n++;
                            $display("%0t: mismatch: expected status %0d found %0d handle %02h",
                                     $time, want.status, want.found, want.fhandle,
                                     ", got status %0d found %0d handle %02h",
                                     got.status, got.found, got.fhandle);
                        end
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                resolve_request(i_req, pred);
                answer_q.push_back(pred);
            end
            o_pending <= answer_q.size();
        end
    end

endmodule

@@ sim/tb_device_match_registry_unit.sv @@
// Testbench top for the device match registry: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb_device_match_registry_unit;
    import dmr_pkg::*;

    localparam int RANDOM_ITEMS = 1428;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HIST_N       = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;

    // receiver stall modes
    localparam int SINK_FREE  = 0;
    localparam int SINK_LIGHT = 1;
    localparam int SINK_HEAVY = 2;
    localparam int SINK_HOLD  = 3;

    // match flag masks
    localparam logic [6:0] M_DEVNO   = 7'(1 << FL_DEVNO);
    localparam logic [6:0] M_CHARS   = 7'(1 << FL_CHARS);
    localparam logic [6:0] M_NOCU    = 7'(1 << FL_NOCU);
    localparam logic [6:0] M_NODEV   = 7'(1 << FL_NODEV);
    localparam logic [6:0] M_CUTYPE  = 7'(1 << FL_CUTYPE);
    localparam logic [6:0] M_DEVTYPE = 7'(1 << FL_DEVTYPE);
    localparam logic [6:0] M_MASKS   = M_NOCU | M_NODEV | M_CUTYPE | M_DEVTYPE;
    localparam logic [6:0] M_ALL     = 7'h7F;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    t_req        req;
    logic        rsp_valid;
    logic        sink_stall;
    logic [1:0]  rsp_status;
    logic        rsp_found;
    logic [7:0]  rsp_handle;
    int          fail_count;
    int          exp_pending;

    int          burst_left;
    logic [15:0] hist_devno [HIST_N];
    logic [47:0] hist_chars [HIST_N];
    int          hist_wr;

    device_match_registry_unit uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (req_valid),
        .o_stall            (req_stall),
        .i_req_type         (req.op),
        .i_handle           (req.handle),
        .i_match_flags      (req.flags),
        .i_dev_number       (req.devno),
        .i_dev_number_valid (req.devno_valid),
        .i_cu_type          (req.chars[47:32]),
        .i_cu_model         (req.chars[31:24]),
        .i_dev_type         (req.chars[23:8]),
        .i_dev_model        (req.chars[7:0]),
        .o_valid            (rsp_valid),
        .i_stall            (sink_stall),
        .o_status           (rsp_status),
        .o_found            (rsp_found),
        .o_found_handle     (rsp_handle)
    );

    dmr_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (req_valid),
        .i_req_stall    (req_stall),
        .i_req          (req),
        .i_rsp_valid    (rsp_valid),
        .i_rsp_stall    (sink_stall),
        .i_status       (rsp_status),
        .i_found        (rsp_found),
        .i_found_handle (rsp_handle),
        .o_fail_count   (fail_count),
        .o_pending      (exp_pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one request; a new burst starts after a random gap
    task automatic issue(input t_req rq);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= rq;
        do @(posedge clk); while (req_stall);
    endtask

    // Receiver stalls: random modes plus two long hold-offs
    initial begin
        int cyc;
        int mode;
        int left;
        cyc = 0;
        mode = SINK_FREE;
        left = 0;
        sink_stall = 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc == 400 || cyc == 3000) begin
                mode = SINK_HOLD;
                left = HOLD_CYCLES;
            end else if (left == 0) begin
                mode = $urandom_range(SINK_FREE, SINK_HEAVY);
                left = $urandom_range(10, 120);
            end
            left--;
            case (mode)
                SINK_FREE:  sink_stall <= 1'b0;
                SINK_LIGHT: sink_stall <= ($urandom_range(0, 3) == 0);
                SINK_HEAVY: sink_stall <= ($urandom_range(0, 3) != 0);
                default:    sink_stall <= 1'b1;
            endcase
        end
    end

    // Watchdog: too many cycles without any handshake
    initial begin
        int idle_n;
        idle_n = 0;
        while (idle_n < IDLE_LIMIT) begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !sink_stall))
                idle_n = 0;
            else
                idle_n++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        t_req rq;
        int   n;
        int   pick;
        int   slot;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        burst_left = 0;
        hist_wr    = 0;
        for (n = 0; n < HIST_N; n++) begin
            hist_devno[n] = 16'($urandom_range(0, 63));
            hist_chars[n] = {16'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                             16'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, bad flags, unused request code
        issue('{OP_SEARCH, 8'h00, 7'h00, 16'h1234, 1'b1, 48'h0});
        issue('{OP_UNREG, 8'h55, 7'h00, 16'h0000, 1'b0, 48'h0});
        issue('{OP_REG, 8'h10, M_ALL & ~(M_DEVNO | M_CHARS), 16'h0001, 1'b0, 48'h1});
        issue('{OP_RSVD, 8'hFF, M_ALL, 16'hFFFF, 1'b1, 48'hFFFF_FFFF_FFFF});
        // fill a few rules, then duplicate handle and both kinds of busy, then more rules
        issue('{OP_REG, 8'h00, M_DEVNO, 16'hFFFF, 1'b0, 48'h0});
        issue('{OP_REG, 8'hFF, FLAGS_EXACT_CHARS, 16'h0000, 1'b1, 48'hFFFF_FFFF_FFFF});
        issue('{OP_REG, 8'hFF, M_DEVNO, 16'h0001, 1'b0, 48'h0});
        issue('{OP_REG, 8'h01, M_DEVNO, 16'hFFFF, 1'b0, 48'h0});
        issue('{OP_REG, 8'h02, FLAGS_EXACT_CHARS, 16'h0002, 1'b0, 48'hFFFF_FFFF_FFFF});
        issue('{OP_REG, 8'h03, M_DEVNO | M_CHARS, 16'h0000, 1'b0, 48'h0});
        issue('{OP_REG, 8'h04, M_CHARS | M_NOCU | M_CUTYPE, 16'h0004, 1'b0,
                48'h1234_56_ABCD_5A});
        issue('{OP_REG, 8'h05, M_CHARS | M_NODEV | M_DEVTYPE, 16'h0005, 1'b0,
                48'h8001_7E_0000_00});
        issue('{OP_REG, 8'h06, M_ALL, 16'h0F0F, 1'b0, 48'h0F0F_F0_F0F0_0F});
        // searches on number, on masked and exact characteristics, and a miss
        issue('{OP_SEARCH, 8'h00, 7'h00, 16'hFFFF, 1'b1, 48'h0});
        issue('{OP_SEARCH, 8'h00, 7'h00, 16'hFFFF, 1'b0, 48'h9999_11_ABCD_5A});
        issue('{OP_SEARCH, 8'h00, 7'h00, 16'h0000, 1'b0, 48'hFFFF_FFFF_FFFF});
        issue('{OP_SEARCH, 8'h00, 7'h00, 16'h0000, 1'b0, 48'h8001_7E_4444_22});
        issue('{OP_SEARCH, 8'h00, 7'h00, 16'h7777, 1'b1, 48'h1111_11_1111_11});
        // remove head, middle and tail, then an already removed handle
        issue('{OP_UNREG, 8'h06, 7'h00, 16'h0000, 1'b0, 48'h0});
        issue('{OP_UNREG, 8'h04, 7'h00, 16'h0000, 1'b0, 48'h0});
        issue('{OP_UNREG, 8'h00, 7'h00, 16'h0000, 1'b0, 48'h0});
        issue('{OP_UNREG, 8'h04, 7'h00, 16'h0000, 1'b0, 48'h0});

        // random traffic over a small handle pool, reusing recent rule contents
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, HIST_N - 1);
            rq.handle = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 39));
            rq.flags  = 7'($urandom);
            case ($urandom_range(0, 3))
                0:       rq.devno = 16'($urandom);
                1:       rq.devno = 16'($urandom_range(0, 63));
                default: rq.devno = hist_devno[slot];
            endcase
            rq.devno_valid = 1'($urandom);
            case ($urandom_range(0, 2))
                0:       rq.chars = {16'($urandom), 32'($urandom)};
                1:       rq.chars = {16'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                                     16'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
                default: rq.chars = hist_chars[slot];
            endcase
            if (pick < 42) begin
                rq.op = OP_REG;
                case ($urandom_range(0, 5))
                    0: rq.flags = M_DEVNO;
                    1: rq.flags = M_CHARS;
                    2: rq.flags = M_DEVNO | M_CHARS;
                    3: rq.flags = FLAGS_EXACT_CHARS;
                    4: rq.flags = M_CHARS | (7'($urandom) & M_MASKS);
                    default: ;
                endcase
                hist_devno[hist_wr] = rq.devno;
                hist_chars[hist_wr] = rq.chars;
                hist_wr = (hist_wr + 1) % HIST_N;
            end else if (pick < 64) begin
                rq.op = OP_UNREG;
            end else if (pick < 97) begin
                rq.op = OP_SEARCH;
                // disturb some fields so masks decide
                if ($urandom_range(0, 3) == 0) rq.chars[47:32] = 16'($urandom);
                if ($urandom_range(0, 3) == 0) rq.chars[31:24] = 8'($urandom);
                if ($urandom_range(0, 3) == 0) rq.chars[23:8]  = 16'($urandom);
                if ($urandom_range(0, 3) == 0) rq.chars[7:0]   = 8'($urandom);
            end else begin
                rq.op = OP_RSVD;
            end
            issue(rq);
        end

        // drain outstanding results
        req_valid <= 1'b0;
        @(negedge clk);
        while (exp_pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/dmr_pkg.sv
rtl/core/dmr_cell.sv
rtl/core/device_match_registry_unit.sv
rtl/core/dmr_checker.sv
sim/dmr_result_checker.sv
sim/tb_device_match_registry_unit.sv
